>>> rtl/core/first_fit_heap_allocator_defines.svh
// Assertion macros for the first-fit heap allocator.
// Used by the top level only; needs aclk and aresetn in scope.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Assert an implication on every clock edge outside reset.
`define FFA_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// Assert an implication that must hold in the next cycle.
`define FFA_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> rtl/core/ffa_pkg.sv
// Package for the first-fit heap allocator: sizes, status codes and
// the command/status structs between controller and datapath.
`timescale 1ns / 1ps

package ffa_pkg;
    localparam int unsigned MaxBlocksDef   = 64;
    localparam int unsigned ArenaBytesDef  = 65536;
    localparam int unsigned HeaderBytesDef = 16;

    localparam int unsigned AddrW = 17;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ALLOC_FAIL = 2'd1;
    localparam logic [1:0] ST_UNKNOWN    = 2'd2;
    localparam logic [1:0] ST_DOUBLE     = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_START   = 4'd1,  // latch request, point at entry 0
        OP_RD      = 4'd2,  // issue read of entry idx
        OP_NEXT    = 4'd3,  // idx++
        OP_ALLOC   = 4'd4,  // mark entry allocated (optionally set size)
        OP_APPEND  = 4'd5,  // write new entry at count
        OP_SH_RD   = 4'd6,  // read entry sh for shifting
        OP_SH_WR   = 4'd7,  // write held entry to sh+/-1
        OP_INS_WR  = 4'd8,  // write split remainder at idx+1
        OP_SETFREE = 4'd9,  // mark idx free
        OP_MERGE   = 4'd10, // add merge size into entry
        OP_RDNB    = 4'd11  // read neighbour
    } ffa_op_t;

    typedef struct packed {
        ffa_op_t    op;
        logic       up;    // shift direction: 1 insert (down to up), 0 remove
        logic       sel;   // operand select for read/merge
    } ffa_cmd_t;

    typedef struct packed {
        logic       is_free;   // registered read: free bit
        logic       fit;       // read entry free and fits
        logic       split;     // fit entry can split
        logic       match;     // read entry start matches address
        logic       at_end;    // idx reached count
        logic       sh_done;   // shifting finished
        logic       zero_req;  // request is zero / null
        logic       app_ok;    // append fits and table not full
        logic       last;      // idx is last entry
        logic       first;     // idx is entry 0
    } ffa_stat_t;
endpackage

>>> rtl/core/first_fit_heap_allocator.sv
// First-fit heap allocator with split and coalesce.
//
// Channels: s_ (cmd, req_size, free_address) in, m_ (status,
// payload_address) out, cfg_ writes heap_limit; all valid/ready.
// One result per command. A command walks the block table one entry
// at a time through a table memory with one read and one write port;
// a split or a merge then shifts the entries above it one at a time.
// One command is in flight at a time; the next s_ beat can come in the
// cycle after the m_ beat.
// Reset (aresetn low, synchronous) empties the table, clears the heap
// end and sets heap_limit to 65536. The table itself is not cleared.
// A stalled result holds on m_ until taken; s_ready stays low until
// then. Configuration is to be written by the user only while no
// command is in flight; the block itself does not enforce this.
// Depends on ffa_pkg, ffa_ctrl, ffa_datapath and the defines header.
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_defines.svh"

module first_fit_heap_allocator import ffa_pkg::*; #(
    parameter int unsigned MAX_BLOCKS   = MaxBlocksDef,
    parameter int unsigned ARENA_BYTES  = ArenaBytesDef,
    parameter int unsigned HEADER_BYTES = HeaderBytesDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [16:0] s_req_size,
    input  logic [15:0] s_free_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_payload_address,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data
);
    ffa_cmd_t    dp_cmd;
    ffa_stat_t   dp_stat;
    logic [16:0] heap_limit_reg;

    assign cfg_ready = 1'b1;

    // Capture the heap limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_limit_reg <= 17'd65536;
        end else if (cfg_valid) begin
            heap_limit_reg <= cfg_data;
        end
    end

    ffa_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_cmd     (s_cmd),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_status (m_status),
        .cmd        (dp_cmd),
        .stat       (dp_stat)
    );

    ffa_datapath #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .ARENA_BYTES  (ARENA_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (dp_cmd),
        .stat       (dp_stat),
        .req_cmd    (s_cmd),
        .req_size   (s_req_size),
        .req_addr   (s_free_address),
        .heap_limit (heap_limit_reg),
        .res_addr   (m_payload_address)
    );

    `FFA_ASSERT_IMPL(a_no_overlap, m_valid, !s_ready, "accept while result pending")
    `FFA_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_status), "result dropped")
    `FFA_ASSERT_IMPL(a_free_addr0, m_valid && m_status != ST_OK, m_payload_address == 16'd0, "address on failure")
endmodule

>>> rtl/core/ffa_datapath.sv
// Datapath of the heap allocator: block table memory, index and shift
// counters, heap end and arithmetic. Depends on ffa_pkg.
`timescale 1ns / 1ps

module ffa_datapath import ffa_pkg::*; #(
    parameter int unsigned MAX_BLOCKS   = MaxBlocksDef,
    parameter int unsigned ARENA_BYTES  = ArenaBytesDef,
    parameter int unsigned HEADER_BYTES = HeaderBytesDef
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ffa_cmd_t          cmd,
    output ffa_stat_t         stat,
    input  logic              req_cmd,
    input  logic [16:0]       req_size,
    input  logic [15:0]       req_addr,
    input  logic [16:0]       heap_limit,
    output logic [15:0]       res_addr
);
    localparam int unsigned IW = $clog2(MAX_BLOCKS);
    localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned EW = AddrW + AddrW + 1;
    localparam logic [AddrW-1:0] Hdr  = AddrW'(HEADER_BYTES);
    localparam logic [AddrW-1:0] Lim  = (ARENA_BYTES > ((1 << AddrW) - 1)) ? {AddrW{1'b1}}
                                                                          : AddrW'(ARENA_BYTES);
    localparam logic [CW-1:0]    MaxC = CW'(MAX_BLOCKS);

    // Table memory: {start, size, free}
    logic [EW-1:0] mem [MAX_BLOCKS];
    logic [EW-1:0] rd_reg;
    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [EW-1:0] wdata;

    logic [CW-1:0]    count_reg, idx_reg, sh_reg;
    logic [AddrW-1:0] heap_end_reg, aligned_reg, msize_reg;
    logic             req_cmd_reg;
    logic             up_reg;
    logic [15:0]      req_addr_reg, res_reg;
    logic [EW-1:0]    hold_reg;

    logic [AddrW-1:0] r_start, r_size;
    logic             r_free;
    logic [AddrW-1:0] aligned, lim_eff;
    logic [AddrW+1:0] need;
    logic [AddrW:0]   split_need;

    assign r_start = rd_reg[EW-1 -: AddrW];
    assign r_size  = rd_reg[AddrW:1];
    assign r_free  = rd_reg[0];
    assign aligned = (req_size + AddrW'(3)) & ~AddrW'(3);
    assign need    = {2'b0, heap_end_reg} + {2'b0, Hdr} + {2'b0, aligned_reg};
    assign lim_eff = (heap_limit < Lim) ? heap_limit : Lim;
    assign split_need = {1'b0, aligned_reg} + {1'b0, Hdr} + (AddrW+1)'(4);

    // Memory port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    always_comb begin
        we    = 1'b0;
        waddr = idx_reg[IW-1:0];
        wdata = rd_reg;
        raddr = idx_reg[IW-1:0];
        case (cmd.op)
            OP_RD: begin
                raddr = idx_reg[IW-1:0];
            end
            OP_RDNB: begin
                raddr = cmd.sel ? IW'(idx_reg - CW'(1)) : IW'(idx_reg + CW'(1));
            end
            OP_SH_RD: begin
                raddr = sh_reg[IW-1:0];
            end
            OP_SH_WR: begin
                we    = 1'b1;
                waddr = cmd.up ? IW'(sh_reg + CW'(1)) : IW'(sh_reg - CW'(1));
                wdata = rd_reg;
            end
            OP_ALLOC: begin
                we    = 1'b1;
                wdata = {r_start, (cmd.sel ? aligned_reg : r_size), 1'b0};
            end
            OP_INS_WR: begin
                we    = 1'b1;
                waddr = IW'(idx_reg + CW'(1));
                wdata = hold_reg;
            end
            OP_APPEND: begin
                we    = 1'b1;
                waddr = count_reg[IW-1:0];
                wdata = {heap_end_reg, aligned_reg, 1'b0};
            end
            OP_SETFREE: begin
                we    = 1'b1;
                wdata = {hold_reg[EW-1 -: AddrW], msize_reg, 1'b1};
            end
            OP_MERGE: begin
                we    = 1'b1;
                waddr = cmd.sel ? IW'(idx_reg - CW'(1)) : idx_reg[IW-1:0];
                wdata = {(cmd.sel ? r_start : hold_reg[EW-1 -: AddrW]),
                         (cmd.sel ? r_size : msize_reg) + Hdr +
                         (cmd.sel ? msize_reg : r_size), 1'b1};
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // Control registers: count, heap end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            heap_end_reg <= '0;
        end else begin
            case (cmd.op)
                OP_APPEND: begin
                    count_reg    <= count_reg + CW'(1);
                    heap_end_reg <= need[AddrW-1:0];
                end
                OP_INS_WR: begin
                    count_reg <= count_reg + CW'(1);
                end
                OP_MERGE: begin
                    count_reg <= count_reg - CW'(1);
                end
                default: begin
                    count_reg <= count_reg;
                end
            endcase
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_START: begin
                idx_reg      <= '0;
                aligned_reg  <= aligned;
                req_cmd_reg  <= req_cmd;
                req_addr_reg <= req_addr;
                res_reg      <= '0;
            end
            OP_NEXT: begin
                idx_reg <= idx_reg + CW'(1);
            end
            OP_ALLOC: begin
                res_reg   <= 16'(r_start + Hdr);
                // remainder entry for a split, and the shift start point
                hold_reg  <= {r_start + Hdr + aligned_reg,
                              r_size - aligned_reg - Hdr, 1'b1};
                sh_reg    <= count_reg - CW'(1);
                up_reg    <= 1'b1;
            end
            OP_APPEND: begin
                res_reg <= 16'(heap_end_reg + Hdr);
            end
            OP_SETFREE: begin
                res_reg <= '0;
            end
            OP_SH_WR: begin
                sh_reg <= cmd.up ? sh_reg - CW'(1) : sh_reg + CW'(1);
            end
            OP_RDNB: begin
                // entering a merge: latch current entry
                if (!cmd.sel) begin
                    hold_reg  <= rd_reg;
                    msize_reg <= r_size;
                end
            end
            OP_MERGE: begin
                up_reg <= 1'b0;
                if (cmd.sel) begin
                    idx_reg   <= idx_reg - CW'(1);
                    msize_reg <= r_size + Hdr + msize_reg;
                    sh_reg    <= idx_reg + CW'(1);
                end else begin
                    msize_reg <= msize_reg + Hdr + r_size;
                    sh_reg    <= idx_reg + CW'(2);
                end
            end
            default: begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    assign res_addr = res_reg;

    // Status to the controller
    always_comb begin
        stat.is_free  = r_free;
        stat.fit      = r_free && (r_size >= aligned_reg);
        stat.split    = ({1'b0, r_size} >= split_need) && (count_reg < MaxC);
        stat.match    = ({1'b0, r_start} + {1'b0, Hdr}) == {2'b0, req_addr_reg};
        stat.at_end   = idx_reg >= count_reg;
        stat.sh_done  = up_reg ? (sh_reg == idx_reg) || (sh_reg < idx_reg + CW'(1))
                               : (sh_reg > count_reg);
        stat.zero_req = req_cmd_reg ? (req_addr_reg == 16'd0) : (aligned_reg == '0);
        stat.app_ok   = (count_reg < MaxC) && (need <= {2'b0, lim_eff});
        stat.last     = (idx_reg + CW'(1)) >= count_reg;
        stat.first    = idx_reg == '0;
    end
endmodule

>>> rtl/core/ffa_ctrl.sv
// Controller of the heap allocator: sequences search, split, append,
// free and merge steps. Depends on ffa_pkg.
`timescale 1ns / 1ps

module ffa_ctrl import ffa_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       in_cmd,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] out_status,
    output ffa_cmd_t   cmd,
    input  ffa_stat_t  stat
);
    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_CHECK  = 15'b000000000000010,
        S_RD     = 15'b000000000000100,
        S_EVAL   = 15'b000000000001000,
        S_SHRD   = 15'b000000000010000,
        S_SHWR   = 15'b000000000100000,
        S_INS    = 15'b000000001000000,
        S_APPEND = 15'b000000010000000,
        S_FREE   = 15'b000000100000000,
        S_RDN    = 15'b000001000000000,
        S_RDP    = 15'b000010000000000,
        S_EVP    = 15'b000100000000000,
        S_RMRD   = 15'b001000000000000,
        S_RMWR   = 15'b010000000000000,
        S_DONE   = 15'b100000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic       op_free_reg, op_free_next;
    logic       prev_reg, prev_next;
    logic [1:0] st_reg, st_next;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_DONE);
    assign out_status = st_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            op_free_reg <= 1'b0;
            prev_reg    <= 1'b0;
            st_reg      <= ST_OK;
        end else begin
            state_reg   <= state_next;
            op_free_reg <= op_free_next;
            prev_reg    <= prev_next;
            st_reg      <= st_next;
        end
    end

    // Sequence one command: search pass, then insert shifting, append, or free and merge shifting
    always_comb begin
        state_next   = state_reg;
        op_free_next = op_free_reg;
        prev_next    = prev_reg;
        st_next      = st_reg;
        cmd          = '{op: OP_NONE, up: 1'b0, sel: 1'b0};
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.op       = OP_START;
                    op_free_next = (in_cmd == CMD_FREE);
                    st_next      = ST_OK;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.zero_req) begin
                    st_next    = op_free_reg ? ST_OK : ST_ALLOC_FAIL;
                    state_next = S_DONE;
                end else begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                if (stat.at_end) begin
                    if (op_free_reg) begin
                        st_next    = ST_UNKNOWN;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_APPEND;
                    end
                end else begin
                    cmd.op     = OP_RD;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (op_free_reg) begin
                    if (stat.match) begin
                        if (stat.is_free) begin
                            st_next    = ST_DOUBLE;
                            state_next = S_DONE;
                        end else begin
                            cmd.op     = OP_RDNB;
                            state_next = S_RDN;
                        end
                    end else begin
                        cmd.op     = OP_NEXT;
                        state_next = S_RD;
                    end
                end else if (stat.fit) begin
                    cmd.op     = OP_ALLOC;
                    cmd.sel    = stat.split;
                    state_next = stat.split ? S_SHRD : S_DONE;
                end else begin
                    cmd.op     = OP_NEXT;
                    state_next = S_RD;
                end
            end
            S_SHRD: begin
                // move entries above idx up by one, top first
                if (stat.sh_done) begin
                    state_next = S_INS;
                end else begin
                    cmd.op     = OP_SH_RD;
                    cmd.up     = 1'b1;
                    state_next = S_SHWR;
                end
            end
            S_SHWR: begin
                cmd.op     = OP_SH_WR;
                cmd.up     = 1'b1;
                state_next = S_SHRD;
            end
            S_INS: begin
                cmd.op     = OP_INS_WR;
                state_next = S_DONE;
            end
            S_APPEND: begin
                if (stat.app_ok) begin
                    cmd.op = OP_APPEND;
                end else begin
                    st_next = ST_ALLOC_FAIL;
                end
                state_next = S_DONE;
            end
            S_RDN: begin
                // neighbour after idx is now in the read register
                prev_next = 1'b0;
                if (stat.last) begin
                    state_next = S_FREE;
                end else if (stat.is_free) begin
                    cmd.op     = OP_MERGE;
                    state_next = S_RMRD;
                end else begin
                    state_next = S_FREE;
                end
            end
            S_FREE: begin
                cmd.op     = OP_SETFREE;
                state_next = stat.first ? S_DONE : S_RDP;
            end
            S_RDP: begin
                cmd.op     = OP_RDNB;
                cmd.sel    = 1'b1;
                state_next = S_EVP;
            end
            S_EVP: begin
                if (stat.is_free) begin
                    cmd.op     = OP_MERGE;
                    cmd.sel    = 1'b1;
                    prev_next  = 1'b1;
                    state_next = S_RMRD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_RMRD: begin
                // close the gap left by the merged entry, bottom first
                if (stat.sh_done) begin
                    state_next = prev_reg ? S_DONE : (stat.first ? S_DONE : S_RDP);
                end else begin
                    cmd.op     = OP_SH_RD;
                    state_next = S_RMWR;
                end
            end
            S_RMWR: begin
                cmd.op     = OP_SH_WR;
                state_next = S_RMRD;
            end
            S_DONE: begin
                if (out_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

>>> tb/sv/first_fit_heap_allocator_checker.sv
// Scoreboard for the first-fit heap allocator: watches s_, m_ and cfg_ beats,
// predicts status and payload address, and counts mismatches. Needs ffa_pkg.
`timescale 1ns / 1ps

module first_fit_heap_allocator_checker import ffa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_cmd,
    input  logic [16:0] s_req_size,
    input  logic [15:0] s_free_address,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [15:0] m_payload_address,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [16:0] cfg_data,
    output int          fail_count,
    output int          pending_count
);
    localparam int NBLK = MaxBlocksDef;
    localparam int HDR  = HeaderBytesDef;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] addr;
    } alloc_result_t;

    // Shadow of the block table
    int unsigned   shadow_start [NBLK];
    int unsigned   shadow_size  [NBLK];
    bit            shadow_free  [NBLK];
    int unsigned   shadow_count;
    int unsigned   shadow_end;
    int unsigned   shadow_limit;
    alloc_result_t results_due[$];

    function automatic void table_open(int unsigned pos, int unsigned st,
                                       int unsigned sz, bit fr);
        for (int unsigned k = shadow_count; k > pos; k--) begin
            shadow_start[k] = shadow_start[k-1];
            shadow_size[k]  = shadow_size[k-1];
            shadow_free[k]  = shadow_free[k-1];
        end
        shadow_start[pos] = st;
        shadow_size[pos]  = sz;
        shadow_free[pos]  = fr;
        shadow_count++;
    endfunction

    function automatic void table_close(int unsigned pos);
        for (int unsigned k = pos; k + 1 < shadow_count; k++) begin
            shadow_start[k] = shadow_start[k+1];
            shadow_size[k]  = shadow_size[k+1];
            shadow_free[k]  = shadow_free[k+1];
        end
        shadow_count--;
    endfunction

    function automatic alloc_result_t heap_command(logic cmd, int unsigned sz,
                                                   int unsigned fa);
        alloc_result_t r;
        int unsigned   al, lim, need, i;
        r.status = ST_OK;
        r.addr   = '0;
        if (cmd == CMD_ALLOC) begin
            if (sz == 0) begin
                r.status = ST_ALLOC_FAIL;
                return r;
            end
            al = (sz + 3) & ~32'd3;
            for (i = 0; i < shadow_count; i++) begin
                if (shadow_free[i] && shadow_size[i] >= al) begin
                    if (shadow_size[i] >= al + HDR + 4 && shadow_count < NBLK) begin
                        table_open(i + 1, shadow_start[i] + HDR + al,
                                   shadow_size[i] - al - HDR, 1'b1);
                        shadow_size[i] = al;
                    end
                    shadow_free[i] = 1'b0;
                    r.addr = 16'(shadow_start[i] + HDR);
                    return r;
                end
            end
            lim  = shadow_limit < ArenaBytesDef ? shadow_limit : ArenaBytesDef;
            need = shadow_end + HDR + al;
            if (shadow_count >= NBLK || need > lim) begin
                r.status = ST_ALLOC_FAIL;
                return r;
            end
            table_open(shadow_count, shadow_end, al, 1'b0);
            r.addr = 16'(shadow_end + HDR);
            shadow_end = need;
        end else begin
            if (fa == 0) return r;
            for (i = 0; i < shadow_count; i++)
                if (shadow_start[i] + HDR == fa) break;
            if (i >= shadow_count) begin
                r.status = ST_UNKNOWN;
                return r;
            end
            if (shadow_free[i]) begin
                r.status = ST_DOUBLE;
                return r;
            end
            shadow_free[i] = 1'b1;
            if (i + 1 < shadow_count && shadow_free[i+1]) begin
                shadow_size[i] += HDR + shadow_size[i+1];
                table_close(i + 1);
            end
            if (i > 0 && shadow_free[i-1]) begin
                shadow_size[i-1] += HDR + shadow_size[i];
                table_close(i);
            end
        end
        return r;
    endfunction

    // Predict on command beats, compare on result beats
    always @(posedge aclk) begin
        alloc_result_t want;
        if (!aresetn) begin
            shadow_count = 0;
            shadow_end   = 0;
            shadow_limit = 65536;
            results_due.delete();
            fail_count    = 0;
            pending_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) shadow_limit = cfg_data;
            if (s_valid && s_ready)
                results_due.push_back(heap_command(s_cmd, s_req_size, s_free_address));
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result status=%0d addr=%0d", $time,
                             m_status, m_payload_address);
                    fail_count++;
                end else begin
                    want = results_due.pop_front();
                    if (want.status !== m_status || want.addr !== m_payload_address) begin
                        $display("%0t: mismatch expected status=%0d addr=%0d, got status=%0d addr=%0d",
                                 $time, want.status, want.addr, m_status, m_payload_address);
                        fail_count++;
                    end
                end
            end
            pending_count = results_due.size();
        end
    end
endmodule

>>> tb/sv/first_fit_heap_allocator_tb.sv
// Stimulus and verdict for the first-fit heap allocator: directed and
// random allocate/free commands. Needs ffa_pkg and the checker module.
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb import ffa_pkg::*; ();

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_cmd = CMD_ALLOC;
    logic [16:0] s_req_size = '0;
    logic [15:0] s_free_address = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [15:0] m_payload_address;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [16:0] cfg_data = '0;
    int          fail_count, pending_count;

    int          idle_pct = 0, stall_pct = 0;
    bit          hold_off = 1'b0;
    int          idle_cycles = 0;
    logic [15:0] live_addr[$];

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    first_fit_heap_allocator dut (.*);

    first_fit_heap_allocator_checker chk (.*);

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_off) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Track allocated addresses for meaningful frees
    always @(posedge aclk)
        if (aresetn && m_valid && m_ready && m_status == ST_OK && m_payload_address != 0)
            live_addr.push_back(m_payload_address);

    // Watchdog: cycles without any beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("first_fit_heap_allocator_tb: FAIL");
            $finish;
        end
    end

    // Valid stays up after a beat until the next command or an idle cycle drops it
    task automatic send_cmd(logic cmd, logic [16:0] sz, logic [15:0] fa);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_cmd          <= cmd;
        s_req_size     <= sz;
        s_free_address <= fa;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
    endtask

    task automatic write_limit(logic [16:0] lim);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly small allocations and frees of live blocks, some noise
    task automatic random_cmd();
        int          pick, j;
        logic [15:0] fa;
        pick = $urandom_range(99);
        if (pick < 45) begin
            send_cmd(CMD_ALLOC, 17'($urandom_range(1, 200)), 16'($urandom));
        end else if (pick < 50) begin
            send_cmd(CMD_ALLOC, 17'($urandom), 16'($urandom));
        end else if (pick < 88 && live_addr.size() > 0) begin
            j  = $urandom_range(live_addr.size() - 1);
            fa = live_addr[j];
            live_addr.delete(j);
            send_cmd(CMD_FREE, 17'($urandom), fa);
        end else begin
            send_cmd(CMD_FREE, 17'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: extremes, zero request, null, unknown and double free
        send_cmd(CMD_ALLOC, 17'd0, 16'hFFFF);
        send_cmd(CMD_FREE, 17'h1FFFF, 16'd0);
        send_cmd(CMD_ALLOC, 17'd1, 16'd0);
        send_cmd(CMD_ALLOC, 17'd100, 16'd0);
        send_cmd(CMD_ALLOC, 17'd8, 16'd0);
        send_cmd(CMD_FREE, 17'd0, 16'd16);
        send_cmd(CMD_FREE, 17'd0, 16'd16);
        send_cmd(CMD_FREE, 17'd0, 16'hFFFF);
        send_cmd(CMD_FREE, 17'd0, 16'd36);
        send_cmd(CMD_ALLOC, 17'd4, 16'd0);
        send_cmd(CMD_ALLOC, 17'h1FFFF, 16'd0);
        send_cmd(CMD_ALLOC, 17'd65536, 16'd0);
        send_cmd(CMD_ALLOC, 17'd65000, 16'd0);
        send_cmd(CMD_FREE, 17'd0, 16'd156);
        // Fill the table to exercise full-table split and append
        for (int k = 0; k < 70; k++) send_cmd(CMD_ALLOC, 17'd4, 16'd0);
        send_cmd(CMD_FREE, 17'd0, 16'd36);
        send_cmd(CMD_ALLOC, 17'd4, 16'd0);

        // Random phases under several limits and idle mixes
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_limit(17'd0);
                1: write_limit(17'h1FFFF);
                2: write_limit(17'd2000);
                3: write_limit(17'd65536);
                4: write_limit(17'd600);
                default: write_limit(17'd65535);
            endcase
            idle_pct  = (ph == 1 || ph == 5) ? 59 : (ph == 3 ? 13 : 0);
            stall_pct = (ph == 2 || ph == 5) ? 59 : (ph == 3 ? 13 : 0);
            // Hold the receiver off while commands keep coming
            if (ph == 4) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (2000) @(negedge aclk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < 130; n++) random_cmd();
        end

        drain();
        if (fail_count == 0)
            $display("first_fit_heap_allocator_tb: PASS");
        else
            $display("first_fit_heap_allocator_tb: FAIL");
        $finish;
    end
endmodule
